/* hw/rtl/leq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leq_pkg
// Shared constants, codes and types of the line editor with line queue.
// ----------------------------------------------------------------------------
package leq_pkg;

  localparam int LINE_LEN    = 64;
  localparam int QUEUE_DEPTH = 8;

  localparam int IDX_W   = $clog2(LINE_LEN);
  localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
  localparam int HELD_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int RING_N  = QUEUE_DEPTH * LINE_LEN;
  localparam int RING_AW = $clog2(RING_N);

  localparam int ACT_W  = 2;
  localparam int CHAR_W = 8;
  localparam int SIZE_W = 7;
  localparam int KIND_W = 3;
  localparam int LEN_W  = 6;
  localparam int DROP_W = 32;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_NUL       = 8'd0;

  typedef enum logic [ACT_W-1:0] {
    ACT_CHAR  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } act_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ECHO    = 3'd0,
    KIND_CHAR    = 3'd1,
    KIND_EMPTY   = 3'd2,
    KIND_NONE    = 3'd3,
    KIND_BADSIZE = 3'd4,
    KIND_DROPS   = 3'd5
  } kind_e;

endpackage

/* hw/rtl/leq_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leq_in_if
// Input channel: one command word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface leq_in_if;
  logic                         valid;
  logic                         ready;
  logic [leq_pkg::ACT_W-1:0]    action;
  logic [leq_pkg::CHAR_W-1:0]   in_char;
  logic [leq_pkg::SIZE_W-1:0]   read_size;

  modport source (output valid, action, in_char, read_size, input ready);
  modport sink   (input valid, action, in_char, read_size, output ready);
endinterface

/* hw/rtl/leq_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leq_out_if
// Output channel: one result word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface leq_out_if;
  logic                         valid;
  logic                         ready;
  logic [leq_pkg::KIND_W-1:0]   kind;
  logic [leq_pkg::CHAR_W-1:0]   out_char;
  logic [leq_pkg::LEN_W-1:0]    line_length;
  logic                         last;
  logic [leq_pkg::DROP_W-1:0]   dropped_count;

  modport source (output valid, kind, out_char, line_length, last, dropped_count,
                  input ready);
  modport sink   (input valid, kind, out_char, line_length, last, dropped_count,
                  output ready);
endinterface

/* hw/rtl/line_editor_with_line_queue_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_editor_with_line_queue_core
// Canonical line editor with a ring of finished lines held in block memories.
// ----------------------------------------------------------------------------
// a word is taken only in ST_IDLE; its first result is registered from ST_EXEC once the output register is free
// typed characters, queries and failed reads pass through ST_EXEC; no new word is taken until back in ST_IDLE
// newline with room in the ring copies the line, one memory word a cycle
// a line read emits one character per cycle from the ring read port while the output register is free
// reset clears the fill, slot pointers, line count and drop counter; memories are not cleared
module line_editor_with_line_queue_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  leq_in_if.sink     in_i,
  leq_out_if.source  out_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_COPY = 4'b0100,
    ST_POP  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [leq_pkg::ACT_W-1:0]   act_q;
  logic [leq_pkg::CHAR_W-1:0]  ch_q;
  logic [leq_pkg::SIZE_W-1:0]  size_q;

  logic [leq_pkg::IDX_W-1:0]   fill_q, fill_d;
  logic [leq_pkg::SLOT_W-1:0]  rslot_q, rslot_d, wslot_q, wslot_d;
  logic [leq_pkg::HELD_W-1:0]  held_q, held_d;
  logic [leq_pkg::DROP_W-1:0]  drops_q, drops_d;

  logic [leq_pkg::IDX_W-1:0]   rd_idx_q, rd_idx_d, wr_idx_q, wr_idx_d;
  logic                        copy_vld_q, copy_vld_d;
  logic [leq_pkg::IDX_W-1:0]   pop_idx_q, pop_idx_d, len_q, len_d;

  logic [leq_pkg::IDX_W-1:0]   sizes_q [leq_pkg::QUEUE_DEPTH];

  logic [leq_pkg::CHAR_W-1:0]  edit_mem [leq_pkg::LINE_LEN];
  logic [leq_pkg::CHAR_W-1:0]  edit_rdata_q;
  logic                        edit_we;

  logic [leq_pkg::CHAR_W-1:0]  ring_mem [leq_pkg::RING_N];
  logic [leq_pkg::CHAR_W-1:0]  ring_rdata_q;
  logic                        ring_we;
  logic [leq_pkg::RING_AW-1:0] ring_waddr, ring_raddr;

  logic                        out_valid_q, out_valid_d, out_free, out_load;
  logic [leq_pkg::KIND_W-1:0]  kind_q, kind_d;
  logic [leq_pkg::CHAR_W-1:0]  och_q, och_d;
  logic [leq_pkg::LEN_W-1:0]   olen_q, olen_d;
  logic                        olast_q, olast_d;
  logic [leq_pkg::DROP_W-1:0]  odrop_q, odrop_d;

  logic [leq_pkg::IDX_W-1:0]   head_size, head_len;
  logic                        in_fire;
  logic                        pop_commit;
  logic                        copy_done;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_free = ~out_valid_q | out_o.ready;

  assign in_i.ready          = (state_q == ST_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = kind_q;
  assign out_o.out_char      = och_q;
  assign out_o.line_length   = olen_q;
  assign out_o.last          = olast_q;
  assign out_o.dropped_count = odrop_q;

  // head line length cut to the reader buffer
  assign head_size = sizes_q[rslot_q];
  assign head_len  = (leq_pkg::SIZE_W'(head_size) >= size_q)
                   ? leq_pkg::IDX_W'(size_q - leq_pkg::SIZE_W'(1)) : head_size;

  assign ring_waddr = leq_pkg::RING_AW'(wslot_q) * leq_pkg::RING_AW'(leq_pkg::LINE_LEN)
                    + leq_pkg::RING_AW'(wr_idx_q);
  assign ring_raddr = leq_pkg::RING_AW'(rslot_q) * leq_pkg::RING_AW'(leq_pkg::LINE_LEN)
                    + leq_pkg::RING_AW'(pop_idx_d);
  assign ring_we    = (state_q == ST_COPY) & copy_vld_q;

  assign copy_done = (state_q == ST_COPY) & (rd_idx_q == fill_q);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rslot_d     = rslot_q;
    wslot_d     = wslot_q;
    held_d      = held_q;
    drops_d     = drops_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    copy_vld_d  = copy_vld_q;
    pop_idx_d   = pop_idx_q;
    len_d       = len_q;
    edit_we     = 1'b0;
    pop_commit  = 1'b0;
    out_load    = 1'b0;
    kind_d      = kind_q;
    och_d       = '0;
    olen_d      = '0;
    olast_d     = 1'b1;
    odrop_d     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
          unique case (leq_pkg::act_e'(act_q))
            leq_pkg::ACT_CHAR: begin
              priority if (ch_q == leq_pkg::CH_BACKSPACE) begin
                if (fill_q != '0) begin
                  fill_d   = fill_q - leq_pkg::IDX_W'(1);
                  out_load = 1'b1;
                  kind_d   = leq_pkg::KIND_ECHO;
                  och_d    = ch_q;
                end
              end else if (ch_q == leq_pkg::CH_NEWLINE) begin
                out_load = 1'b1;
                kind_d   = leq_pkg::KIND_ECHO;
                och_d    = ch_q;
                if (held_q == leq_pkg::HELD_W'(leq_pkg::QUEUE_DEPTH)) begin
                  drops_d = drops_q + leq_pkg::DROP_W'(1);
                  fill_d  = '0;
                end else begin
                  state_d    = ST_COPY;
                  rd_idx_d   = '0;
                  copy_vld_d = 1'b0;
                end
              end else if (ch_q == leq_pkg::CH_NUL) begin
                state_d = ST_IDLE;
              end else if (fill_q == leq_pkg::IDX_W'(leq_pkg::LINE_LEN - 1)) begin
                state_d = ST_IDLE;
              end else begin
                edit_we  = 1'b1;
                fill_d   = fill_q + leq_pkg::IDX_W'(1);
                out_load = 1'b1;
                kind_d   = leq_pkg::KIND_ECHO;
                och_d    = ch_q;
              end
            end
            leq_pkg::ACT_READ: begin
              out_load = 1'b1;
              priority if (size_q == '0) begin
                kind_d = leq_pkg::KIND_BADSIZE;
              end else if (held_q == '0) begin
                kind_d = leq_pkg::KIND_NONE;
              end else if (head_len == '0) begin
                kind_d     = leq_pkg::KIND_EMPTY;
                pop_commit = 1'b1;
              end else begin
                out_load  = 1'b0;
                len_d     = head_len;
                pop_idx_d = '0;
                state_d   = ST_POP;
              end
            end
            leq_pkg::ACT_QUERY: begin
              out_load = 1'b1;
              kind_d   = leq_pkg::KIND_DROPS;
              odrop_d  = drops_q;
            end
            leq_pkg::ACT_NONE: begin
              state_d = ST_IDLE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_COPY: begin
        if (rd_idx_q == fill_q) begin
          // copy finished: queue the line and restart the edit line
          copy_vld_d = 1'b0;
          state_d    = ST_IDLE;
          fill_d     = '0;
          wslot_d    = (wslot_q == leq_pkg::SLOT_W'(leq_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wslot_q + leq_pkg::SLOT_W'(1);
          held_d     = held_q + leq_pkg::HELD_W'(1);
        end else begin
          rd_idx_d   = rd_idx_q + leq_pkg::IDX_W'(1);
          wr_idx_d   = rd_idx_q;
          copy_vld_d = 1'b1;
        end
      end
      ST_POP: begin
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = leq_pkg::KIND_CHAR;
          och_d    = ring_rdata_q;
          olen_d   = leq_pkg::LEN_W'(len_q);
          olast_d  = (pop_idx_q == len_q - leq_pkg::IDX_W'(1));
          if (olast_d) begin
            pop_commit = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            pop_idx_d = pop_idx_q + leq_pkg::IDX_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (pop_commit) begin
      rslot_d = (rslot_q == leq_pkg::SLOT_W'(leq_pkg::QUEUE_DEPTH - 1))
              ? '0 : rslot_q + leq_pkg::SLOT_W'(1);
      held_d  = held_q - leq_pkg::HELD_W'(1);
    end

    out_valid_d = out_load | (out_valid_q & ~out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      rslot_q     <= '0;
      wslot_q     <= '0;
      held_q      <= '0;
      drops_q     <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      copy_vld_q  <= 1'b0;
      pop_idx_q   <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rslot_q     <= rslot_d;
      wslot_q     <= wslot_d;
      held_q      <= held_d;
      drops_q     <= drops_d;
      rd_idx_q    <= rd_idx_d;
      wr_idx_q    <= wr_idx_d;
      copy_vld_q  <= copy_vld_d;
      pop_idx_q   <= pop_idx_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q  <= in_i.action;
      ch_q   <= in_i.in_char;
      size_q <= in_i.read_size;
    end
    if (out_load) begin
      kind_q  <= kind_d;
      och_q   <= och_d;
      olen_q  <= olen_d;
      olast_q <= olast_d;
      odrop_q <= odrop_d;
    end
    if (copy_done) begin
      sizes_q[wslot_q] <= fill_q;
    end
  end

  // edit line memory
  always_ff @(posedge clk_i) begin
    if (edit_we) begin
      edit_mem[fill_q] <= ch_q;
    end
    edit_rdata_q <= edit_mem[rd_idx_q];
  end

  // finished line ring memory
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= edit_rdata_q;
    end
    ring_rdata_q <= ring_mem[ring_raddr];
  end

`ifndef ASSERT_OFF
  a_held_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= leq_pkg::HELD_W'(leq_pkg::QUEUE_DEPTH))
    else $error("line count above ring depth");

  a_copy_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> (held_q < leq_pkg::HELD_W'(leq_pkg::QUEUE_DEPTH)))
    else $error("line copy into a full ring");

  a_pop_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> (pop_idx_q < len_q) && (held_q != '0))
    else $error("pop index past line length");

  a_char_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == leq_pkg::KIND_CHAR) |-> (olen_q != '0))
    else $error("line character with zero length");
`endif

endmodule
